FILE: sv/bpfl_pkg.sv
package bpfl_pkg;

    localparam int CMD_W    = 3;
    localparam int STATUS_W = 2;

    typedef enum logic [CMD_W-1:0] {
        CMD_ALLOC      = 3'd0,
        CMD_LINK       = 3'd1,
        CMD_FREE_CHAIN = 3'd2,
        CMD_GET_NEXT   = 3'd3,
        CMD_REINIT     = 3'd4
    } t_cmd;

    typedef enum logic [STATUS_W-1:0] {
        STS_OK       = 2'd0,
        STS_EMPTY    = 2'd1,
        STS_OVERLONG = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_ALLOC,
        S_GET,
        S_WALK_RD,
        S_WALK_WR,
        S_DONE
    } t_state;

endpackage

FILE: sv/bpfl_ram.sv
module bpfl_ram #(
    parameter int WIDTH = 5,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: sv/buffer_pool_free_list_core.sv
// Free-list allocator for a pool of POOL_BUFFERS fixed-size buffers, handles 1 to
// POOL_BUFFERS, 0 being null. The next links live in a single-port-read,
// single-port-write RAM with a registered read port; a valid bit per entry makes
// reset and reinit take effect at once (an unwritten entry k reads as k minus one).
// Every command returns one item. Link, reinit, unused commands and the empty,
// null and out-of-range cases of alloc and get_next go straight to the result
// stage; alloc and get_next first do one RAM read, and free_chain does a read and a
// write per buffer walked, for at most POOL_BUFFERS buffers. The next item is
// accepted in the cycle after the result is registered, even while that result
// still waits to be taken.
module buffer_pool_free_list_core #(
    parameter int POOL_BUFFERS = 16
) (
    input  logic                                     i_clk,
    input  logic                                     i_rst_n,
    input  logic                                     i_in_valid,
    output logic                                     o_in_ready,
    input  logic [bpfl_pkg::CMD_W-1:0]               i_cmd,
    input  logic [$clog2(POOL_BUFFERS+1)-1:0]        i_first_handle,
    input  logic [$clog2(POOL_BUFFERS+1)-1:0]        i_second_handle,
    output logic                                     o_out_valid,
    input  logic                                     i_out_ready,
    output logic [$clog2(POOL_BUFFERS+1)-1:0]        o_result_handle,
    output logic [bpfl_pkg::STATUS_W-1:0]            o_status
);
    import bpfl_pkg::*;

    localparam int W  = $clog2(POOL_BUFFERS + 1);
    localparam int AW = $clog2(POOL_BUFFERS);

    function automatic logic handle_ok(input logic [W-1:0] h);
        return (h != '0) && (h <= W'(POOL_BUFFERS));
    endfunction

    function automatic logic [AW-1:0] to_idx(input logic [W-1:0] h);
        logic [W-1:0] d;
        d = h - W'(1);
        return d[AW-1:0];
    endfunction

    t_state                  r_state, n_state;
    logic [W-1:0]            r_head, n_head;
    logic [W-1:0]            r_h, n_h;
    logic [W-1:0]            r_cnt, n_cnt;
    logic [AW-1:0]           r_idx, n_idx;
    logic [W-1:0]            r_res, n_res;
    logic [STATUS_W-1:0]     r_st, n_st;
    logic [POOL_BUFFERS-1:0] r_valid, n_valid;
    logic                    r_o_valid, n_o_valid;
    logic [W-1:0]            r_o_res, n_o_res;
    logic [STATUS_W-1:0]     r_o_st, n_o_st;

    logic          ram_we, ram_re;
    logic [AW-1:0] ram_waddr, ram_raddr;
    logic [W-1:0]  ram_wdata, ram_rdata;
    logic [W-1:0]  eff_link;
    logic          accept;

    bpfl_ram #(
        .WIDTH (W),
        .DEPTH (POOL_BUFFERS)
    ) u_link_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign o_in_ready      = (r_state == S_IDLE);
    assign accept          = i_in_valid && o_in_ready;
    assign eff_link        = r_valid[r_idx] ? ram_rdata : W'(r_idx);
    assign o_out_valid     = r_o_valid;
    assign o_result_handle = r_o_res;
    assign o_status        = r_o_st;

    always_comb begin
        n_state   = r_state;
        n_head    = r_head;
        n_h       = r_h;
        n_cnt     = r_cnt;
        n_idx     = r_idx;
        n_res     = r_res;
        n_st      = r_st;
        n_valid   = r_valid;
        n_o_valid = r_o_valid;
        n_o_res   = r_o_res;
        n_o_st    = r_o_st;
        ram_we    = 1'b0;
        ram_waddr = r_idx;
        ram_wdata = '0;
        ram_re    = 1'b0;
        ram_raddr = r_idx;

        if (r_o_valid && i_out_ready) begin
            n_o_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_res   = '0;
                    n_st    = STS_OK;
                    n_state = S_DONE;
                    case (i_cmd)
                        CMD_ALLOC: begin
                            if (handle_ok(r_head)) begin
                                ram_re    = 1'b1;
                                ram_raddr = to_idx(r_head);
                                n_idx     = to_idx(r_head);
                                n_state   = S_ALLOC;
                            end else begin
                                n_st = STS_EMPTY;
                            end
                        end
                        CMD_LINK: begin
                            if (handle_ok(i_first_handle) &&
                                (i_second_handle == '0 || handle_ok(i_second_handle))) begin
                                ram_we                          = 1'b1;
                                ram_waddr                       = to_idx(i_first_handle);
                                ram_wdata                       = i_second_handle;
                                n_valid[to_idx(i_first_handle)] = 1'b1;
                            end
                        end
                        CMD_FREE_CHAIN: begin
                            n_h     = i_first_handle;
                            n_cnt   = '0;
                            n_state = S_WALK_RD;
                        end
                        CMD_GET_NEXT: begin
                            if (handle_ok(i_first_handle)) begin
                                ram_re    = 1'b1;
                                ram_raddr = to_idx(i_first_handle);
                                n_idx     = to_idx(i_first_handle);
                                n_state   = S_GET;
                            end
                        end
                        CMD_REINIT: begin
                            n_valid = '0;
                            n_head  = W'(POOL_BUFFERS);
                        end
                        default: begin
                            n_state = S_DONE;
                        end
                    endcase
                end
            end
            S_ALLOC: begin
                n_res          = r_head;
                n_head         = eff_link;
                ram_we         = 1'b1;
                ram_waddr      = r_idx;
                ram_wdata      = '0;
                n_valid[r_idx] = 1'b1;
                n_state        = S_DONE;
            end
            S_GET: begin
                n_res   = eff_link;
                n_state = S_DONE;
            end
            S_WALK_RD: begin
                if (!handle_ok(r_h)) begin
                    n_state = S_DONE;
                end else if (r_cnt == W'(POOL_BUFFERS)) begin
                    n_st    = STS_OVERLONG;
                    n_state = S_DONE;
                end else begin
                    ram_re    = 1'b1;
                    ram_raddr = to_idx(r_h);
                    n_idx     = to_idx(r_h);
                    n_state   = S_WALK_WR;
                end
            end
            S_WALK_WR: begin
                ram_we         = 1'b1;
                ram_waddr      = r_idx;
                ram_wdata      = r_head;
                n_valid[r_idx] = 1'b1;
                n_head         = r_h;
                n_h            = eff_link;
                n_cnt          = r_cnt + W'(1);
                n_state        = S_WALK_RD;
            end
            S_DONE: begin
                if (!r_o_valid || i_out_ready) begin
                    n_o_valid = 1'b1;
                    n_o_res   = r_res;
                    n_o_st    = r_st;
                    n_state   = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_head    <= W'(POOL_BUFFERS);
            r_valid   <= '0;
            r_o_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_head    <= n_head;
            r_valid   <= n_valid;
            r_o_valid <= n_o_valid;
        end
        r_h     <= n_h;
        r_cnt   <= n_cnt;
        r_idx   <= n_idx;
        r_res   <= n_res;
        r_st    <= n_st;
        r_o_res <= n_o_res;
        r_o_st  <= n_o_st;
    end

    a_head_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_head == '0) || handle_ok(r_head))
        else $error("free-list head out of range");

    a_no_write_on_read_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_GET || r_state == S_DONE || r_state == S_WALK_RD) |-> !ram_we)
        else $error("link write outside a modifying state");

    a_walk_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WALK_RD || r_state == S_WALK_WR) |-> (r_cnt <= W'(POOL_BUFFERS)))
        else $error("chain walk beyond pool size");

    a_walk_handle_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WALK_WR) |-> (handle_ok(r_h) && r_idx == to_idx(r_h)))
        else $error("walk pushing an invalid handle");

    a_result_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && r_o_valid && !i_out_ready) |=> (r_state == S_DONE))
        else $error("result dropped while output stalled");

endmodule

FILE: tb/sv/tb_buffer_pool_free_list_core.sv
`timescale 1ns / 100ps

module tb_buffer_pool_free_list_core;

    import bpfl_pkg::*;

    localparam int POOL         = 16;
    localparam int HW           = $clog2(POOL + 1);
    localparam int RANDOM_ITEMS = 1850;
    localparam int CYCLE_LIMIT  = 1000000;
    localparam int SETTLE       = 2 + 2 * POOL + 8;

    localparam logic [CMD_W-1:0] CMD_SPARE_LO = 3'd5;
    localparam logic [CMD_W-1:0] CMD_SPARE_HI = 3'd7;

    typedef struct packed {
        logic [HW-1:0] res;
        t_status       sts;
    } result_t;

    typedef struct packed {
        logic [CMD_W-1:0] cmd;
        logic [HW-1:0]    first;
        logic [HW-1:0]    second;
        logic             known;
        logic [HW-1:0]    res;
        t_status          sts;
    } dir_row_t;

    logic                  i_clk;
    logic                  i_rst_n         = 1'b0;
    logic                  i_in_valid      = 1'b0;
    logic                  o_in_ready;
    logic [CMD_W-1:0]      i_cmd           = '0;
    logic [HW-1:0]         i_first_handle  = '0;
    logic [HW-1:0]         i_second_handle = '0;
    logic                  o_out_valid;
    logic                  i_out_ready     = 1'b0;
    logic [HW-1:0]         o_result_handle;
    logic [STATUS_W-1:0]   o_status;

    buffer_pool_free_list_core #(
        .POOL_BUFFERS(POOL)
    ) dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_cmd           (i_cmd),
        .i_first_handle  (i_first_handle),
        .i_second_handle (i_second_handle),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_result_handle (o_result_handle),
        .o_status        (o_status)
    );

    // Free-list image
    logic [HW-1:0] link_mem [1:POOL];
    logic [HW-1:0] head_buf;

    result_t pending_results [$];
    result_t oldest;
    int      err_count  = 0;
    int      items_sent = 0;
    int      cyc_count  = 0;
    int      burst_left = 0;
    int      calm_left  = 0;

    dir_row_t dir_rows [0:25] = '{
        '{CMD_GET_NEXT,   5'd16, 5'd0,  1'b1, 5'd15, STS_OK},
        '{CMD_GET_NEXT,   5'd1,  5'd0,  1'b1, 5'd0,  STS_OK},
        '{CMD_GET_NEXT,   5'd0,  5'd31, 1'b1, 5'd0,  STS_OK},
        '{CMD_GET_NEXT,   5'd31, 5'd0,  1'b1, 5'd0,  STS_OK},
        '{CMD_ALLOC,      5'd0,  5'd0,  1'b1, 5'd16, STS_OK},
        '{CMD_ALLOC,      5'd31, 5'd31, 1'b1, 5'd15, STS_OK},
        '{CMD_LINK,       5'd16, 5'd15, 1'b0, 5'd0,  STS_OK},
        '{CMD_LINK,       5'd15, 5'd16, 1'b0, 5'd0,  STS_OK},
        '{CMD_LINK,       5'd17, 5'd3,  1'b0, 5'd0,  STS_OK},
        '{CMD_LINK,       5'd3,  5'd31, 1'b0, 5'd0,  STS_OK},
        '{CMD_LINK,       5'd0,  5'd5,  1'b0, 5'd0,  STS_OK},
        '{CMD_GET_NEXT,   5'd16, 5'd0,  1'b0, 5'd0,  STS_OK},
        '{CMD_FREE_CHAIN, 5'd16, 5'd0,  1'b0, 5'd0,  STS_OK},
        '{CMD_FREE_CHAIN, 5'd0,  5'd0,  1'b1, 5'd0,  STS_OK},
        '{CMD_FREE_CHAIN, 5'd31, 5'd0,  1'b1, 5'd0,  STS_OK},
        '{CMD_REINIT,     5'd0,  5'd0,  1'b1, 5'd0,  STS_OK},
        '{CMD_LINK,       5'd1,  5'd2,  1'b0, 5'd0,  STS_OK},
        '{CMD_LINK,       5'd2,  5'd1,  1'b0, 5'd0,  STS_OK},
        '{CMD_FREE_CHAIN, 5'd1,  5'd0,  1'b1, 5'd0,  STS_OVERLONG},
        '{CMD_REINIT,     5'd17, 5'd17, 1'b1, 5'd0,  STS_OK},
        '{CMD_LINK,       5'd16, 5'd0,  1'b0, 5'd0,  STS_OK},
        '{CMD_ALLOC,      5'd0,  5'd0,  1'b1, 5'd16, STS_OK},
        '{CMD_ALLOC,      5'd0,  5'd0,  1'b1, 5'd0,  STS_EMPTY},
        '{CMD_SPARE_LO,   5'd16, 5'd16, 1'b1, 5'd0,  STS_OK},
        '{CMD_SPARE_HI,   5'd31, 5'd1,  1'b1, 5'd0,  STS_OK},
        '{CMD_REINIT,     5'd0,  5'd0,  1'b1, 5'd0,  STS_OK}
    };

    function automatic logic in_pool(input logic [HW-1:0] h);
        return (h >= 1) && (h <= POOL);
    endfunction

    task automatic rebuild_pool();
        for (int k = 1; k <= POOL; k++) begin
            link_mem[k] = HW'(k - 1);
        end
        head_buf = HW'(POOL);
    endtask

    task automatic pool_step(input logic [CMD_W-1:0] cmd, input logic [HW-1:0] a,
                             input logic [HW-1:0] b, output logic [HW-1:0] res,
                             output t_status sts);
        logic [HW-1:0] h;
        logic [HW-1:0] nx;
        int            cnt;
        res = '0;
        sts = STS_OK;
        case (cmd)
            CMD_ALLOC: begin
                if (!in_pool(head_buf)) begin
                    sts = STS_EMPTY;
                end else begin
                    res           = head_buf;
                    head_buf      = link_mem[res];
                    link_mem[res] = '0;
                end
            end
            CMD_LINK: begin
                if (in_pool(a) && (b == 0 || in_pool(b))) begin
                    link_mem[a] = b;
                end
            end
            CMD_FREE_CHAIN: begin
                h   = a;
                cnt = 0;
                while (in_pool(h)) begin
                    if (cnt >= POOL) begin
                        sts = STS_OVERLONG;
                        break;
                    end
                    nx          = link_mem[h];
                    link_mem[h] = head_buf;
                    head_buf    = h;
                    h           = nx;
                    cnt++;
                end
            end
            CMD_GET_NEXT: begin
                if (in_pool(a)) begin
                    res = link_mem[a];
                end
            end
            CMD_REINIT: begin
                rebuild_pool();
            end
            default: begin
            end
        endcase
    endtask

    task automatic flag_mismatch(input string what);
        $display("[%0t] mismatch: %s", $realtime, what);
        err_count++;
    endtask

    task automatic send_item(input logic [CMD_W-1:0] cmd, input logic [HW-1:0] a,
                             input logic [HW-1:0] b, input logic known,
                             input logic [HW-1:0] k_res, input t_status k_sts,
                             output logic [HW-1:0] got);
        logic [HW-1:0] p_res;
        t_status       p_sts;
        int            gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 12);
            if (calm_left > 0) begin
                calm_left--;
            end else begin
                gap = $urandom_range(1, 6);
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
                if ($urandom_range(0, 29) == 0) begin
                    calm_left = $urandom_range(5, 15);
                end
            end
        end
        burst_left--;
        i_in_valid      <= 1'b1;
        i_cmd           <= cmd;
        i_first_handle  <= a;
        i_second_handle <= b;
        do @(posedge i_clk); while (!o_in_ready);
        pool_step(cmd, a, b, p_res, p_sts);
        if (known) begin
            pending_results.push_back('{k_res, k_sts});
        end else begin
            pending_results.push_back('{p_res, p_sts});
        end
        if (cmd <= CMD_REINIT) begin
            items_sent++;
        end
        got = p_res;
    endtask

    task automatic send_cmd(input logic [CMD_W-1:0] cmd, input logic [HW-1:0] a,
                            input logic [HW-1:0] b, output logic [HW-1:0] got);
        send_item(cmd, a, b, 1'b0, '0, STS_OK, got);
    endtask

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        rebuild_pool();
    end

    always @(posedge i_clk) begin
        cyc_count <= cyc_count + 1;
        if (cyc_count >= CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    // Receiver: check the oldest expected item, then stall on a cycling pattern
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_results.size() == 0) begin
                flag_mismatch($sformatf("unexpected item handle=%0d status=%0d",
                                        o_result_handle, o_status));
            end else begin
                oldest = pending_results.pop_front();
                if (o_result_handle !== oldest.res) begin
                    flag_mismatch($sformatf("handle %0d, want %0d",
                                            o_result_handle, oldest.res));
                end
                if (o_status !== oldest.sts) begin
                    flag_mismatch($sformatf("status %0d, want %0d",
                                            o_status, oldest.sts));
                end
            end
        end
        if (cyc_count % 256 < 64) begin
            i_out_ready <= 1'b1;
        end else if (cyc_count % 256 < 160) begin
            i_out_ready <= ($urandom_range(0, 1) == 1);
        end else begin
            i_out_ready <= ($urandom_range(0, 3) == 0);
        end
    end

    initial begin
        logic [HW-1:0] got;
        logic [HW-1:0] owned [$];
        logic [CMD_W-1:0] c;
        int            n;
        int            sel;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_rows[r]) begin
            send_item(dir_rows[r].cmd, dir_rows[r].first, dir_rows[r].second,
                      dir_rows[r].known, dir_rows[r].res, dir_rows[r].sts, got);
        end

        while (items_sent < RANDOM_ITEMS) begin
            sel = $urandom_range(0, 99);
            if (sel < 60) begin
                // Allocate a few buffers, chain them, then hand the chain back
                n = ($urandom_range(0, 19) == 0) ? $urandom_range(12, 18)
                                                 : $urandom_range(1, 6);
                owned.delete();
                for (int k = 0; k < n; k++) begin
                    send_cmd(CMD_ALLOC, HW'($urandom_range(0, 31)), '0, got);
                    if (got != 0) begin
                        owned.push_back(got);
                    end
                end
                for (int k = 0; k + 1 < owned.size(); k++) begin
                    send_cmd(CMD_LINK, owned[k], owned[k + 1], got);
                end
                if (owned.size() > 0) begin
                    if ($urandom_range(0, 9) == 0) begin
                        send_cmd(CMD_LINK, owned[owned.size() - 1], owned[0], got);
                    end else begin
                        send_cmd(CMD_LINK, owned[owned.size() - 1], '0, got);
                    end
                    if ($urandom_range(0, 1) == 1) begin
                        send_cmd(CMD_GET_NEXT, owned[$urandom_range(0, owned.size() - 1)],
                                 HW'($urandom_range(0, 31)), got);
                    end
                    if ($urandom_range(0, 7) != 0) begin
                        send_cmd(CMD_FREE_CHAIN, owned[0], '0, got);
                    end
                end
            end else if (sel < 85) begin
                c = CMD_W'($urandom_range(0, 7));
                if (c == CMD_REINIT && $urandom_range(0, 3) != 0) begin
                    c = CMD_GET_NEXT;
                end
                send_cmd(c, HW'($urandom_range(0, 31)), HW'($urandom_range(0, 31)), got);
            end else if (sel < 97) begin
                send_cmd(CMD_GET_NEXT, HW'($urandom_range(1, POOL)), '0, got);
            end else begin
                send_cmd(CMD_REINIT, '0, '0, got);
            end
        end

        @(posedge i_clk);
        i_in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);

        if (err_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

FILE: buffer_pool_free_list_core.f
sv/bpfl_pkg.sv
sv/bpfl_ram.sv
sv/buffer_pool_free_list_core.sv
tb/sv/tb_buffer_pool_free_list_core.sv
